### hdl/rlsf_pkg.sv
package rlsf_pkg;

  localparam int DefaultMaxRows = 256;
  localparam int DefaultMaxCols = 256;

  localparam int LabelW   = 32;
  localparam int CoordW   = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_PASS_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROWS       = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COLS       = 2'd2;

  localparam logic [7:0] PassCountReset = 8'd1;
  localparam logic [8:0] RowsReset      = 9'd256;
  localparam logic [8:0] ColsReset      = 9'd256;

  typedef struct packed {
    logic [1:0]               command;
    logic [CoordW-1:0]        cell_row;
    logic [CoordW-1:0]        cell_col;
    logic signed [LabelW-1:0] link_label;
    logic                     ridge_flag;
  } in_item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [LabelW-1:0] cell_label;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pass_count;
    logic [8:0] rows_in_use;
    logic [8:0] cols_in_use;
  } cfg_t;

  typedef struct packed {
    logic                     ridge;
    logic signed [LabelW-1:0] label;
  } cell_word_t;

  typedef enum logic [2:0] {
    MEM_NONE       = 3'd0,
    MEM_LOAD       = 3'd1,
    MEM_READ_IN    = 3'd2,
    MEM_READ_HERE  = 3'd3,
    MEM_READ_VERT  = 3'd4,
    MEM_READ_HORZ  = 3'd5,
    MEM_WRITE_CELL = 3'd6
  } mem_op_e;

  typedef struct packed {
    mem_op_e mem_op;
    logic    run_start;
    logic    sweep_start;
    logic    cell_advance;
    logic    dir_next;
    logic    out_load_read;
    logic    out_load_done;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_zero;
    logic sweep_empty;
    logic last_cell;
    logic out_free;
  } dp_status_t;

endpackage

### hdl/rlsf_ctrl.sv
module rlsf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_command_i,
  input  rlsf_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output rlsf_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RDATA  = 8'b0000_0010,
    S_SWEEP  = 8'b0000_0100,
    S_HERE   = 8'b0000_1000,
    S_VERT   = 8'b0001_0000,
    S_HORZ   = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mem_op = rlsf_pkg::MEM_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (in_command_i == rlsf_pkg::CMD_LOAD) begin
            cmd_o.mem_op = rlsf_pkg::MEM_LOAD;
          end else if (in_command_i == rlsf_pkg::CMD_READ) begin
            cmd_o.mem_op = rlsf_pkg::MEM_READ_IN;
            state_d      = S_RDATA;
          end else if (in_command_i == rlsf_pkg::CMD_RUN) begin
            cmd_o.run_start = 1'b1;
            state_d         = S_SWEEP;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RDATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load_read = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_SWEEP: begin
        priority if (status_i.pass_zero) begin
          state_d = S_FINISH;
        end else if (status_i.sweep_empty) begin
          cmd_o.dir_next = 1'b1;
        end else begin
          cmd_o.sweep_start = 1'b1;
          state_d           = S_HERE;
        end
      end
      S_HERE: begin
        cmd_o.mem_op = rlsf_pkg::MEM_READ_HERE;
        state_d      = S_VERT;
      end
      S_VERT: begin
        cmd_o.mem_op = rlsf_pkg::MEM_READ_VERT;
        state_d      = S_HORZ;
      end
      S_HORZ: begin
        cmd_o.mem_op = rlsf_pkg::MEM_READ_HORZ;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.mem_op = rlsf_pkg::MEM_WRITE_CELL;
        if (status_i.last_cell) begin
          cmd_o.dir_next = 1'b1;
          state_d        = S_SWEEP;
        end else begin
          cmd_o.cell_advance = 1'b1;
          state_d            = S_HERE;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load_done = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/rlsf_dp.sv
module rlsf_dp #(
  parameter int MaxRows = rlsf_pkg::DefaultMaxRows,
  parameter int MaxCols = rlsf_pkg::DefaultMaxCols
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rlsf_pkg::in_item_t    in_item_i,
  input  rlsf_pkg::cfg_t        cfg_i,
  input  rlsf_pkg::dp_cmd_t     cmd_i,
  output rlsf_pkg::dp_status_t  status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output rlsf_pkg::out_item_t   out_item_o
);

  localparam int RowW  = $clog2(MaxRows);
  localparam int ColW  = $clog2(MaxCols);
  localparam int NRowW = $clog2(MaxRows + 1);
  localparam int NColW = $clog2(MaxCols + 1);
  localparam int AddrW = RowW + ColW;
  localparam int Depth = 1 << AddrW;

  rlsf_pkg::cell_word_t cell_mem_q [Depth];
  rlsf_pkg::cell_word_t rdata_q, here_q, vert_q, wdata;
  logic [AddrW-1:0]     raddr, waddr;
  logic                 re, we;

  logic [NRowW-1:0] nrows;
  logic [NColW-1:0] ncols;
  logic [RowW-1:0]  row_q, row_first, row_last, row_vert;
  logic [ColW-1:0]  col_q, col_first, col_last, col_horz;
  logic             dir_q;
  logic [7:0]       pass_left_q;

  logic [AddrW-1:0] in_addr;
  logic             in_range, read_inside_q;
  logic             fill_en;
  logic signed [rlsf_pkg::LabelW-1:0] fill_label;

  logic                out_valid_q;
  rlsf_pkg::out_item_t out_item_q;

  assign nrows = (32'(cfg_i.rows_in_use) > MaxRows) ? NRowW'(MaxRows)
                                                    : NRowW'(cfg_i.rows_in_use);
  assign ncols = (32'(cfg_i.cols_in_use) > MaxCols) ? NColW'(MaxCols)
                                                    : NColW'(cfg_i.cols_in_use);

  // The forward sweep runs from 1 up to size-2, the reverse from size-3 down to 2.
  assign row_first = dir_q ? RowW'(nrows - NRowW'(3)) : RowW'(1);
  assign row_last  = dir_q ? RowW'(2) : RowW'(nrows - NRowW'(2));
  assign col_first = dir_q ? ColW'(ncols - NColW'(3)) : ColW'(1);
  assign col_last  = dir_q ? ColW'(2) : ColW'(ncols - NColW'(2));
  assign row_vert  = dir_q ? row_q + RowW'(1) : row_q - RowW'(1);
  assign col_horz  = dir_q ? col_q + ColW'(1) : col_q - ColW'(1);

  assign status_o.pass_zero   = (pass_left_q == 8'd0);
  assign status_o.sweep_empty = dir_q ? (nrows < NRowW'(5) || ncols < NColW'(5))
                                      : (nrows < NRowW'(3) || ncols < NColW'(3));
  assign status_o.last_cell   = (row_q == row_last) && (col_q == col_last);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      pass_left_q <= 8'd0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (cmd_i.run_start) begin
        pass_left_q <= cfg_i.pass_count;
        dir_q       <= 1'b0;
      end
      if (cmd_i.sweep_start) begin
        row_q <= row_first;
        col_q <= col_first;
      end
      if (cmd_i.cell_advance) begin
        if (col_q == col_last) begin
          col_q <= col_first;
          row_q <= dir_q ? row_q - RowW'(1) : row_q + RowW'(1);
        end else begin
          col_q <= dir_q ? col_q - ColW'(1) : col_q + ColW'(1);
        end
      end
      if (cmd_i.dir_next) begin
        if (dir_q) begin
          dir_q       <= 1'b0;
          pass_left_q <= pass_left_q - 8'd1;
        end else begin
          dir_q <= 1'b1;
        end
      end
    end
  end

  assign in_range = (32'(in_item_i.cell_row) < MaxRows) && (32'(in_item_i.cell_col) < MaxCols);
  assign in_addr  = {RowW'(in_item_i.cell_row), ColW'(in_item_i.cell_col)};

  // An unlabeled hillslope cell takes the vertical neighbor first; the horizontal
  // neighbor, when usable, overrides it.
  always_comb begin
    fill_en    = (here_q.label == '0) && !here_q.ridge;
    fill_label = here_q.label;
    if (vert_q.label != '0 && !vert_q.ridge) begin
      fill_label = vert_q.label;
    end
    if (rdata_q.label != '0 && !rdata_q.ridge) begin
      fill_label = rdata_q.label;
    end
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = {row_q, col_q};
    waddr = {row_q, col_q};
    wdata = '0;
    unique case (cmd_i.mem_op)
      rlsf_pkg::MEM_LOAD: begin
        we          = in_range;
        waddr       = in_addr;
        wdata.ridge = in_item_i.ridge_flag;
        wdata.label = in_item_i.ridge_flag ? '0 : in_item_i.link_label;
      end
      rlsf_pkg::MEM_READ_IN: begin
        re    = 1'b1;
        raddr = in_addr;
      end
      rlsf_pkg::MEM_READ_HERE: begin
        re = 1'b1;
      end
      rlsf_pkg::MEM_READ_VERT: begin
        re    = 1'b1;
        raddr = {row_vert, col_q};
      end
      rlsf_pkg::MEM_READ_HORZ: begin
        re    = 1'b1;
        raddr = {row_q, col_horz};
      end
      rlsf_pkg::MEM_WRITE_CELL: begin
        we          = fill_en;
        wdata.ridge = 1'b0;
        wdata.label = fill_label;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cell_mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= cell_mem_q[raddr];
    end
    if (cmd_i.mem_op == rlsf_pkg::MEM_READ_VERT) begin
      here_q <= rdata_q;
    end
    if (cmd_i.mem_op == rlsf_pkg::MEM_READ_HORZ) begin
      vert_q <= rdata_q;
    end
    if (cmd_i.mem_op == rlsf_pkg::MEM_READ_IN) begin
      read_inside_q <= in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_read || cmd_i.out_load_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_read) begin
      out_item_q.result_kind <= rlsf_pkg::KIND_READ;
      out_item_q.cell_label  <= read_inside_q ? rdata_q.label : '0;
    end else if (cmd_i.out_load_done) begin
      out_item_q.result_kind <= rlsf_pkg::KIND_DONE;
      out_item_q.cell_label  <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### hdl/raster_label_sweep_fill.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o   | in_item_i (rlsf_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_item_o (rlsf_pkg::out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load item leaves the input ready for the next item; a read item holds the input until
// its result enters the output register. During a run the single read port of the cell store
// serves three reads per visited cell (S_HERE, S_VERT, S_HORZ) before the write in S_WRITE.
// Reset returns the control and configuration to their reset values only; the cell store is undefined until loaded.
// A stalled result waits in the output register while loads continue to be accepted.
module raster_label_sweep_fill #(
  parameter int MaxRows = rlsf_pkg::DefaultMaxRows,
  parameter int MaxCols = rlsf_pkg::DefaultMaxCols
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rlsf_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rlsf_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rlsf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rlsf_pkg::CfgDataW-1:0]     cfg_data_i
);

  rlsf_pkg::cfg_t       cfg_q;
  rlsf_pkg::dp_cmd_t    dp_cmd;
  rlsf_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pass_count  <= rlsf_pkg::PassCountReset;
      cfg_q.rows_in_use <= rlsf_pkg::RowsReset;
      cfg_q.cols_in_use <= rlsf_pkg::ColsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == rlsf_pkg::REG_PASS_COUNT) begin
        cfg_q.pass_count <= cfg_data_i[7:0];
      end
      if (cfg_index_i == rlsf_pkg::REG_ROWS) begin
        cfg_q.rows_in_use <= cfg_data_i;
      end
      if (cfg_index_i == rlsf_pkg::REG_COLS) begin
        cfg_q.cols_in_use <= cfg_data_i;
      end
    end
  end

  rlsf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_item_i.command),
    .status_i     (dp_status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (dp_cmd)
  );

  rlsf_dp #(
    .MaxRows (MaxRows),
    .MaxCols (MaxCols)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  a_load_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.command == rlsf_pkg::CMD_LOAD |=> in_ready_o)
    else $error("load item stalled the input");

  a_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.command == rlsf_pkg::CMD_READ |=> !in_ready_o)
    else $error("read item did not wait for its data");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a pending read or run");

  a_no_write_on_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.run_start |-> !dp_cmd.out_load_done && !dp_cmd.out_load_read)
    else $error("run start and result load in one cycle");

endmodule
